### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the datapath of the range majority vote tree.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rmvt_pkg.sv
// ----------------------------------------------------------------------------
// rmvt_pkg
// Request and response types, mode codes and controller/datapath links.
// ----------------------------------------------------------------------------
package rmvt_pkg;

   localparam logic MODE_SET   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [9:0]  position;
      logic [10:0] right_bound;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] candidate;
      logic [10:0] margin;
   } rsp_type;

   // Commands from the controller, one step of datapath work each.
   typedef struct packed {
      logic load;
      logic clear;
      logic set_leaf;
      logic set_climb;
      logic query_step;
      logic drain;
      logic emit;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic is_set;
      logic set_ok;
      logic query_empty;
      logic clear_last;
      logic climb_last;
      logic query_last;
      logic rsp_free;
   } status_type;

endpackage

### hdl/rmvt_ram.sv
// ----------------------------------------------------------------------------
// rmvt_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmvt_ram #(
   parameter int WIDTH = 43,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### hdl/rmvt_ctrl.sv
// ----------------------------------------------------------------------------
// rmvt_ctrl
// Sequencer: clearing pass, leaf update climb, range fold and result hand-off.
// ----------------------------------------------------------------------------
module rmvt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rmvt_pkg::status_type status,
   output rmvt_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR     = 7'b0000001,
      ST_IDLE      = 7'b0000010,
      ST_SET_LEAF  = 7'b0000100,
      ST_SET_CLIMB = 7'b0001000,
      ST_QUERY     = 7'b0010000,
      ST_DRAIN     = 7'b0100000,
      ST_FINAL     = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) begin
               if (status.is_set) begin
                  state_in = status.set_ok ? ST_SET_LEAF : ST_IDLE;
               end else begin
                  state_in = status.query_empty ? ST_FINAL : ST_QUERY;
               end
            end
         end
         ST_SET_LEAF: begin
            cmd.set_leaf = 1'b1;
            state_in     = ST_SET_CLIMB;
         end
         ST_SET_CLIMB: begin
            cmd.set_climb = 1'b1;
            if (status.climb_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            cmd.query_step = 1'b1;
            if (status.query_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = ST_FINAL;
         end
         ST_FINAL: begin
            // hold the result until the output register is free
            cmd.emit = status.rsp_free;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/rmvt_dp.sv
// ----------------------------------------------------------------------------
// rmvt_dp
// Datapath: node memory, vote merge units, range pointers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmvt_dp #(
   parameter int LEAVES     = 1024,
   parameter int LEVELS     = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rmvt_pkg::req_type    req_data,
   output rmvt_pkg::rsp_type    rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rmvt_pkg::cmd_type    cmd,
   output rmvt_pkg::status_type status
);

   localparam int NODE_BITS = LEVELS + 1;
   localparam int CNT_BITS  = LEVELS + 1;
   localparam int PTR_BITS  = LEVELS + 2;
   localparam int WORD_BITS = VALUE_BITS + CNT_BITS;
   localparam int NODES     = 2 * LEAVES;
   localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(NODES - 1);
   localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);
   localparam logic [31:0]          LEAVES_W  = 32'(LEAVES);

   typedef struct packed {
      logic [VALUE_BITS-1:0] cand;
      logic [CNT_BITS-1:0]   count;
   } vote_type;

   function automatic vote_type vote_merge(vote_type a, vote_type b);
      vote_type res;
      if (a.cand == b.cand) begin
         res.cand  = a.cand;
         res.count = a.count + b.count;
      end else if (a.count >= b.count) begin
         res.cand  = a.cand;
         res.count = a.count - b.count;
      end else begin
         res.cand  = b.cand;
         res.count = b.count - a.count;
      end
      return res;
   endfunction

   // registers
   logic [NODE_BITS-1:0]  clr_ff, clr_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   vote_type              carry_ff, carry_in;
   logic [PTR_BITS-1:0]   l_ff, l_in;
   logic [PTR_BITS-1:0]   r_ff, r_in;
   logic                  pend_l_ff, pend_l_in;
   logic                  pend_r_ff, pend_r_in;
   vote_type              acc_l_ff, acc_l_in;
   vote_type              acc_r_ff, acc_r_in;
   rmvt_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                  wr_en;
   logic [NODE_BITS-1:0]  wr_addr;
   vote_type              wr_data;
   logic [NODE_BITS-1:0]  rd_addr_a, rd_addr_b;
   logic [WORD_BITS-1:0]  rd_word_a, rd_word_b;
   vote_type              rd_a, rd_b;

   // request decode
   logic [31:0]           pos_w, rb_w, rb_clamp;
   vote_type              leaf_vote, climb_vote, final_vote;
   logic [NODE_BITS-1:0]  parent;
   logic [PTR_BITS-1:0]   l_sum, r_dec, l_next, r_next, r_last;
   vote_type              acc_l_merged, acc_r_merged;

   assign rd_a = vote_type'(rd_word_a);
   assign rd_b = vote_type'(rd_word_b);

   assign pos_w    = 32'(req_data.position);
   assign rb_w     = 32'(req_data.right_bound);
   assign rb_clamp = (rb_w > LEAVES_W) ? LEAVES_W : rb_w;

   assign leaf_vote.cand  = value_ff;
   assign leaf_vote.count = CNT_BITS'(1);

   // the updated child sits on the left when its index is even
   assign parent     = node_ff >> 1;
   assign climb_vote = node_ff[0] ? vote_merge(rd_a, carry_ff) : vote_merge(carry_ff, rd_a);

   assign l_sum  = l_ff + PTR_BITS'(l_ff[0]);
   assign r_dec  = r_ff - PTR_BITS'(r_ff[0]);
   assign l_next = l_sum >> 1;
   assign r_next = r_dec >> 1;
   assign r_last = r_ff - PTR_BITS'(1);

   assign acc_l_merged = pend_l_ff ? vote_merge(acc_l_ff, rd_a) : acc_l_ff;
   assign acc_r_merged = pend_r_ff ? vote_merge(rd_b, acc_r_ff) : acc_r_ff;
   assign final_vote   = vote_merge(acc_l_ff, acc_r_ff);

   always_comb begin
      clr_in       = clr_ff;
      node_in      = node_ff;
      value_in     = value_ff;
      carry_in     = carry_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      pend_l_in    = pend_l_ff;
      pend_r_in    = pend_r_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      if (cmd.clear) begin
         wr_en  = 1'b1;
         clr_in = clr_ff + NODE_BITS'(1);
      end
      if (cmd.load) begin
         node_in   = NODE_BITS'(pos_w + LEAVES_W);
         value_in  = VALUE_BITS'(req_data.value);
         l_in      = PTR_BITS'(pos_w + LEAVES_W);
         r_in      = PTR_BITS'(rb_clamp + LEAVES_W);
         pend_l_in = 1'b0;
         pend_r_in = 1'b0;
         acc_l_in  = '0;
         acc_r_in  = '0;
      end
      if (cmd.set_leaf) begin
         wr_en     = 1'b1;
         wr_addr   = node_ff;
         wr_data   = leaf_vote;
         carry_in  = leaf_vote;
         rd_addr_a = node_ff ^ NODE_BITS'(1);
      end
      if (cmd.set_climb) begin
         wr_en     = 1'b1;
         wr_addr   = parent;
         wr_data   = climb_vote;
         carry_in  = climb_vote;
         node_in   = parent;
         rd_addr_a = parent ^ NODE_BITS'(1);
      end
      if (cmd.query_step) begin
         rd_addr_a = l_ff[NODE_BITS-1:0];
         rd_addr_b = r_last[NODE_BITS-1:0];
         acc_l_in  = acc_l_merged;
         acc_r_in  = acc_r_merged;
         pend_l_in = l_ff[0];
         pend_r_in = r_ff[0];
         l_in      = l_next;
         r_in      = r_next;
      end
      if (cmd.drain) begin
         acc_l_in  = acc_l_merged;
         acc_r_in  = acc_r_merged;
         pend_l_in = 1'b0;
         pend_r_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_in.candidate = 32'(final_vote.cand);
         rsp_in.margin    = 11'(final_vote.count);
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pend_l_ff    <= 1'b0;
         pend_r_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         pend_l_ff    <= pend_l_in;
         pend_r_ff    <= pend_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff  <= node_in;
      value_ff <= value_in;
      carry_ff <= carry_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
      rsp_ff   <= rsp_in;
   end

   rmvt_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NODES)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (WORD_BITS'(wr_data)),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_word_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_word_b)
   );

   assign status.is_set      = (req_data.mode == rmvt_pkg::MODE_SET);
   assign status.set_ok      = (pos_w < LEAVES_W);
   assign status.query_empty = !(pos_w < rb_clamp);
   assign status.clear_last  = (clr_ff == LAST_NODE);
   assign status.climb_last  = (parent == ROOT_NODE);
   assign status.query_last  = !(l_next < r_next);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_HOLDS(a_fold_in_range, clock, reset, !cmd.query_step || (l_ff < r_ff), "empty fold")
   `ASSERT_HOLDS(a_emit_drained, clock, reset, !cmd.emit || !(pend_l_ff || pend_r_ff), "undrained")
   `ASSERT_HOLDS(a_emit_slot_free, clock, reset, !cmd.emit || status.rsp_free, "output busy")
   `ASSERT_HOLDS(a_climb_root, clock, reset, !cmd.set_climb || node_ff > ROOT_NODE, "above root")
   `ASSERT_NEXT(a_drain_follows, clock, reset, cmd.query_step && status.query_last, cmd.drain, "no drain")

endmodule

### hdl/range_majority_vote_tree.sv
// ----------------------------------------------------------------------------
// range_majority_vote_tree
// Segment tree of Boyer-Moore vote pairs with leaf set and range query.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                                   handshake
//   req_      in         mode, position, right_bound, value        valid/stall
//   rsp_      out        candidate, margin (one per query request) valid/stall
//
// After reset a clearing pass writes (0, 0) into all 2*LEAVES nodes, one node a
// cycle; req_stall stays high until the pass is done.
// A set request steps through accept, leaf write and one merge per level.
// A query request steps through accept, at most one memory step per tree
// level (LEVELS+1 levels, two node reads per step), drain and final merge;
// an empty range skips straight to the final merge.
// The response sits in an output register, so requests keep flowing while an
// unaccepted response waits; only the next query's final merge holds on it.
//
module range_majority_vote_tree #(
   parameter int LEAVES     = 1024,
   parameter int LEVELS     = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmvt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmvt_pkg::rsp_type rsp_data
);

   // command and status link between sequencer and datapath
   rmvt_pkg::cmd_type    cmd;
   rmvt_pkg::status_type status;

   // sequencer: clear, climb a set up to the root, fold a range level by level
   rmvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: node memory, merge units, pointers and the response register
   rmvt_dp #(
      .LEAVES     (LEAVES),
      .LEVELS     (LEVELS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
